### design/pixel_difference_predictor_assert.svh
// assertion macros for the pixel difference predictor
`ifndef PIXEL_DIFFERENCE_PREDICTOR_ASSERT_SVH
`define PIXEL_DIFFERENCE_PREDICTOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PDP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdp check failed");

// next-cycle implication
`define PDP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdp check failed");

`else

`define PDP_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define PDP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### design/pdp_pkg.sv
// shared types and constants of the pixel difference predictor
package pdp_pkg;

    // fixed field widths
    localparam int PIX_W = 8;
    localparam int RES_W = 9;
    localparam int CFG_W = 13;
    // wide enough for any clamped dimension up to 65536
    localparam int DIM_W = 17;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // saturation limits of the view byte
    localparam logic signed [RES_W-1:0] VIEW_LOW  = -9'sd127;
    localparam logic signed [RES_W-1:0] VIEW_HIGH = 9'sd127;
    localparam logic [PIX_W-1:0]        VIEW_MAX  = 8'd255;
    localparam logic [PIX_W-1:0]        VIEW_MIN  = 8'd0;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

    // one classified word: sample, its prediction, frame end flag
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] pred;
        logic             frame_end;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_stat;

endpackage

### design/pdp_ram.sv
// generic single-write, single-read ram with registered read
module pdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pdp_front.sv
// front: raster position, line buffer and prediction select
module pdp_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pdp_pkg::t_cfg            i_cfg,
    input  logic [pdp_pkg::PIX_W-1:0] i_pixel,
    input  logic                     i_pixel_valid,
    output logic                     o_pixel_ready,
    input  pdp_pkg::t_q_stat         i_q_stat,
    output logic                     o_push,
    output pdp_pkg::t_item           o_item
);

    import pdp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_left;
    logic             r_s1_above;
    logic             r_s1_end;
    logic [PIX_W-1:0] above;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             accept, last_col, last_row, top_row, first_pix;

    // clamp dimensions to 1..max
    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = DIM_W'(1);
        end else if (DIM_W'(i_cfg.width) > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = DIM_W'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = DIM_W'(1);
        end else if (DIM_W'(i_cfg.height) > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = DIM_W'(i_cfg.height);
        end
    end

    // room for the staged word and a new one
    assign o_pixel_ready = ({1'b0, i_q_stat.count} + (QCNT_W+1)'(r_s1_valid))
                           < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = i_pixel_valid && o_pixel_ready;
    assign top_row   = (r_row == '0);
    assign first_pix = top_row && (r_col == '0);
    assign last_col  = (DIM_W'(r_col) + DIM_W'(1)) >= w_eff;
    assign last_row  = (DIM_W'(r_row) + DIM_W'(1)) >= h_eff;

    // next raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // line buffer: old row read and new row written at the same column
    pdp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // position and left neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= i_pixel;
            end
        end
    end

    // classification stage, waits for the line buffer read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_pixel;
            r_s1_left  <= first_pix ? '0 : r_left;
            r_s1_above <= !top_row;
            r_s1_end   <= last_col && last_row;
        end
    end

    assign o_push         = r_s1_valid;
    assign o_item.pix     = r_s1_pix;
    assign o_item.pred    = r_s1_above ? above : r_s1_left;
    assign o_item.frame_end = r_s1_end;

endmodule

### design/pdp_queue.sv
// short fifo of classified words between front and back
module pdp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pdp_pkg::t_item   i_item,
    input  logic             i_pop,
    output pdp_pkg::t_item   o_item,
    output pdp_pkg::t_q_stat o_stat
);

    import pdp_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [QCNT_W-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + QPTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item       = r_mem[r_head];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

endmodule

### design/pdp_back.sv
// back: residual, view byte and output register
module pdp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdp_pkg::t_item                  i_item,
    input  pdp_pkg::t_q_stat                i_q_stat,
    output logic                            o_pop,
    output logic signed [pdp_pkg::RES_W-1:0] o_residual,
    output logic [pdp_pkg::PIX_W-1:0]       o_view_byte,
    output logic                            o_frame_end,
    output logic                            o_res_valid,
    input  logic                            i_res_ready
);

    import pdp_pkg::*;

    logic signed [RES_W-1:0] res;
    logic [PIX_W-1:0]        view;
    logic                    r_valid;
    logic signed [RES_W-1:0] r_residual;
    logic [PIX_W-1:0]        r_view;
    logic                    r_end;

    // difference and saturated offset
    always_comb begin
        res = signed'({1'b0, i_item.pix}) - signed'({1'b0, i_item.pred});
        if (res < VIEW_LOW) begin
            view = VIEW_MIN;
        end else if (res > VIEW_HIGH) begin
            view = VIEW_MAX;
        end else begin
            // adding 128 within range flips the top bit
            view = res[PIX_W-1:0] ^ 8'h80;
        end
    end

    // take a word when the output register is free or draining
    assign o_pop = !i_q_stat.empty && (!r_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_residual <= res;
            r_view     <= view;
            r_end      <= i_item.frame_end;
        end
    end

    assign o_res_valid = r_valid;
    assign o_residual  = r_residual;
    assign o_view_byte = r_view;
    assign o_frame_end = r_end;

endmodule

### design/pixel_difference_predictor.sv
// top level of the pixel difference predictor
//
// usage:
//   input channel: 8-bit grayscale pixels in raster order on i_pixel, taken when
//   i_pixel_valid and o_pixel_ready are both high. output channel: one word per
//   pixel (o_residual, o_view_byte, o_frame_end) taken when o_res_valid and
//   i_res_ready are both high. o_frame_end marks the last pixel of a frame.
//   apb port: image_width at byte address 0, image_height at 4; write while idle.
//   path: a taken pixel passes the line buffer read stage, the fifo and the
//   output register before it appears at the output.
//   throughput: one pixel per clock while o_pixel_ready stays high, set by the line
//   buffer port pair (read old row and write new row at the same column each cycle).
//   reset clears position, left neighbour, fifo and output valid; the line
//   buffer holds no reset and is filled by the first row of each frame.
//   when the receiver stalls, the four-entry fifo absorbs words in flight and
//   o_pixel_ready drops once it cannot take another one.
`include "pixel_difference_predictor_assert.svh"
module pixel_difference_predictor #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic [pdp_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_pixel_valid,
    output logic                             o_pixel_ready,
    output logic signed [pdp_pkg::RES_W-1:0] o_residual,
    output logic [pdp_pkg::PIX_W-1:0]        o_view_byte,
    output logic                             o_frame_end,
    output logic                             o_res_valid,
    input  logic                             i_res_ready
);

    import pdp_pkg::*;

    logic [CFG_W-1:0] r_image_width, r_image_height;
    t_cfg             cfg;
    t_item            push_item, head_item;
    t_q_stat          q_stat;
    logic             push, pop, cfg_write;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(4096);
            r_image_height <= CFG_W'(4096);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    assign cfg.width  = r_image_width;
    assign cfg.height = r_image_height;

    pdp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_pixel       (i_pixel),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (push_item)
    );

    pdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    pdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_residual  (o_residual),
        .o_view_byte (o_view_byte),
        .o_frame_end (o_frame_end),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready)
    );

    // fifo never overfills
    `PDP_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    // every taken pixel is pushed into the fifo in the next cycle
    `PDP_ASSERT_NEXT(a_push_follows, i_clk, i_rst_n, i_pixel_valid && o_pixel_ready, push)
    // a waiting word fills an output register that is free or draining
    `PDP_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, !q_stat.empty && (!o_res_valid || i_res_ready), o_res_valid)

endmodule

### verif/tb_pixel_difference_predictor.sv
// self-checking testbench of the pixel difference predictor
`timescale 1ns / 1ps
module tb_pixel_difference_predictor;
    import pdp_pkg::*;

    localparam int unsigned MAX_DIM      = 4096;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned NUM_ROWS     = 25;
    localparam int unsigned SAT_PIXELS   = 30;
    localparam int          VIEW_FLOOR   = -127;
    localparam int          VIEW_CEIL    = 127;
    localparam int          VIEW_OFFSET  = 128;
    localparam logic [2:0]  ADDR_WIDTH   = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [2:0]  ADDR_HEIGHT  = {REG_IMAGE_HEIGHT, 2'b00};
    localparam int          IDLE_SEND [4] = '{0, 63, 0, 31};
    localparam int          IDLE_RECV [4] = '{0, 0, 63, 31};

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic [PIX_W-1:0]        view;
        logic                    frame_end;
    } t_word;

    typedef enum logic {ROW_PIXEL, ROW_SHAPE} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [PIX_W-1:0] pix;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             typed;
        t_word            want;
    } t_row;

    // directed words: extremes of the residual and view byte, mid-frame shrink,
    // first pixel of a frame, one-pixel frames
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_PIXEL, 8'd255, 13'd0, 13'd0, 1'b1, '{9'sd255, 8'd255, 1'b0}},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{-9'sd255, 8'd0, 1'b0}},
        '{ROW_PIXEL, 8'd127, 13'd0, 13'd0, 1'b1, '{9'sd127, 8'd255, 1'b0}},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{-9'sd127, 8'd1, 1'b0}},
        '{ROW_PIXEL, 8'd128, 13'd0, 13'd0, 1'b1, '{9'sd128, 8'd255, 1'b0}},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{-9'sd128, 8'd0, 1'b0}},
        '{ROW_PIXEL, 8'd1,   13'd0, 13'd0, 1'b1, '{9'sd1, 8'd129, 1'b0}},
        '{ROW_PIXEL, 8'd1,   13'd0, 13'd0, 1'b1, '{9'sd0, 8'd128, 1'b0}},
        '{ROW_SHAPE, 8'd0,   13'd4, 13'd2, 1'b0, '0},
        '{ROW_PIXEL, 8'd100, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{-9'sd255, 8'd0, 1'b0}},
        '{ROW_PIXEL, 8'd255, 13'd0, 13'd0, 1'b1, '{9'sd255, 8'd255, 1'b0}},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{-9'sd127, 8'd1, 1'b0}},
        '{ROW_PIXEL, 8'd255, 13'd0, 13'd0, 1'b1, '{9'sd255, 8'd255, 1'b1}},
        '{ROW_PIXEL, 8'd200, 13'd0, 13'd0, 1'b1, '{9'sd200, 8'd255, 1'b0}},
        '{ROW_PIXEL, 8'd73,  13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd73,  13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd73,  13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd255, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd37,  13'd0, 13'd0, 1'b0, '0},
        '{ROW_PIXEL, 8'd200, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_SHAPE, 8'd0,   13'd1, 13'd1, 1'b0, '0},
        '{ROW_PIXEL, 8'd0,   13'd0, 13'd0, 1'b1, '{9'sd0, 8'd128, 1'b1}},
        '{ROW_PIXEL, 8'd255, 13'd0, 13'd0, 1'b1, '{9'sd255, 8'd255, 1'b1}}
    };

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [2:0]              paddr         = '0;
    logic [31:0]             pwdata        = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic [PIX_W-1:0]        i_pixel       = '0;
    logic                    i_pixel_valid = 1'b0;
    logic                    o_pixel_ready;
    logic signed [RES_W-1:0] o_residual;
    logic [PIX_W-1:0]        o_view_byte;
    logic                    o_frame_end;
    logic                    o_res_valid;
    logic                    i_res_ready   = 1'b0;

    // predictor state and its copy of the registers
    logic [PIX_W-1:0] line_buf [MAX_DIM];
    logic [PIX_W-1:0] prev_pix    = '0;
    int unsigned      col_pos     = 0;
    int unsigned      row_pos     = 0;
    int unsigned      cols_filled = 0;
    logic [CFG_W-1:0] cfg_width   = 13'd4096;
    logic [CFG_W-1:0] cfg_height  = 13'd4096;

    t_word       pending_words [$];
    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned error_count   = 0;
    int unsigned frames_seen   = 0;
    int unsigned reg_writes    = 0;
    int unsigned reshapes      = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_ack      = 0;
    int unsigned hold_left     = 0;

    pixel_difference_predictor #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_pixel       (i_pixel),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .o_residual    (o_residual),
        .o_view_byte   (o_view_byte),
        .o_frame_end   (o_frame_end),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // zero means one, anything past the line buffer saturates
    function automatic int unsigned frame_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // residual against left or above neighbour, then advance the raster position
    function automatic t_word predict_word(input logic [PIX_W-1:0] pix);
        int          diff;
        int unsigned w;
        int unsigned h;
        logic        last_col;
        logic        last_row;
        t_word       word;
        w = frame_dim(cfg_width);
        h = frame_dim(cfg_height);
        if (row_pos == 0) begin
            diff = (col_pos == 0) ? int'(pix) : int'(pix) - int'(prev_pix);
        end else begin
            diff = int'(pix) - int'(line_buf[col_pos]);
        end
        line_buf[col_pos] = pix;
        if (col_pos + 1 > cols_filled) cols_filled = col_pos + 1;
        prev_pix = pix;
        word.residual = 9'(diff);
        word.view = (diff < VIEW_FLOOR) ? 8'd0 :
                    (diff > VIEW_CEIL) ? 8'd255 : 8'(diff + VIEW_OFFSET);
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        word.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        if (word.frame_end) frames_seen++;
        return word;
    endfunction

    // mostly uniform, some rail values, some smooth runs
    function automatic logic [PIX_W-1:0] random_pixel();
        int v;
        case ($urandom_range(3))
            1: begin
                return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            end
            2: begin
                v = int'(prev_pix) + int'($urandom_range(8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
            default: begin
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        // keep the log short once things go wrong
        if (error_count < 40) begin
            $display("mismatch on word %0d: %s got %0d expected %0d",
                     words_out, what, got, want);
        end
        error_count++;
    endtask

    // offer one pixel, predict its word once it is taken
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                              input t_word typed_word);
        t_word word;
        while ($urandom_range(99) < send_idle_pct) begin
            i_pixel_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pixel       <= pix;
        i_pixel_valid <= 1'b1;
        do @(posedge i_clk); while (!o_pixel_ready);
        word = predict_word(pix);
        pending_words.push_back(typed ? typed_word : word);
        words_in++;
    endtask

    // wait until every taken pixel has come back
    task automatic wait_idle();
        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (words_out < words_in);
    endtask

    // two back-to-back apb writes: width then height
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_WIDTH;
        pwdata  <= 32'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        paddr   <= ADDR_HEIGHT;
        pwdata  <= 32'(h);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        reg_writes += 2;
    endtask

    task automatic pick_dims(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h);
        case ($urandom_range(15))
            0: begin
                w = '0;
                h = 13'($urandom_range(0, 6));
            end
            1: begin
                w = 13'($urandom_range(40, 160));
                h = 13'($urandom_range(0, 2));
            end
            default: begin
                w = 13'($urandom_range(1, 20));
                h = 13'($urandom_range(0, 6));
            end
        endcase
    endtask

    // whole frames of random shape, now and then reshaped part way through
    task automatic run_frames(input int unsigned quota);
        int unsigned      start;
        int unsigned      cut;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        start = words_in;
        while (words_in - start < quota) begin
            wait_idle();
            pick_dims(w, h);
            set_frame(w, h);
            cut = ($urandom_range(3) == 0) ? $urandom_range(1, 30) : 0;
            do begin
                send_pixel(random_pixel(), 1'b0, '0);
                if (cut != 0) begin
                    cut--;
                    if (cut == 0 && (col_pos != 0 || row_pos != 0)) begin
                        // position keeps running; past row 0 only narrow to filled columns
                        wait_idle();
                        pick_dims(w, h);
                        if (row_pos != 0) begin
                            w = 13'($urandom_range(0, (cols_filled < 32) ? cols_filled : 32));
                        end
                        set_frame(w, h);
                        reshapes++;
                    end
                end
            end while (col_pos != 0 || row_pos != 0);
        end
    endtask

    task automatic send_frame();
        do send_pixel(random_pixel(), 1'b0, '0); while (col_pos != 0 || row_pos != 0);
    endtask

    // a stretch of a saturated frame, then shrink to one pixel so the next word closes it
    task automatic send_saturated(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        set_frame(w, h);
        repeat (SAT_PIXELS) send_pixel(random_pixel(), 1'b0, '0);
        wait_idle();
        set_frame(13'd1, 13'd1);
        reshapes++;
        send_frame();
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_res_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // check each delivered word against the oldest prediction
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            words_out <= words_out + 1;
            if (pending_words.size() == 0) begin
                report_mismatch("word with none pending, residual", int'(o_residual), 0);
            end else begin
                want = pending_words.pop_front();
                if (o_residual !== want.residual) begin
                    report_mismatch("residual", int'(o_residual), int'(want.residual));
                end
                if (o_view_byte !== want.view) begin
                    report_mismatch("view byte", int'(o_view_byte), int'(want.view));
                end
                if (o_frame_end !== want.frame_end) begin
                    report_mismatch("frame end", int'(o_frame_end), int'(want.frame_end));
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at full rate
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_SHAPE) begin
                wait_idle();
                set_frame(DIRECTED_ROWS[i].width, DIRECTED_ROWS[i].height);
            end else begin
                send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].want);
            end
        end

        // receiver holds off while pixels keep coming, input must back up
        wait_idle();
        hold_req <= hold_req + 1;
        run_frames(80);

        // random frames under each idle mix
        for (int m = 0; m < 4; m++) begin
            send_idle_pct = IDLE_SEND[m];
            stall_pct    <= IDLE_RECV[m];
            run_frames(340);
        end

        // saturated width with zero height, then zero width with saturated height
        send_idle_pct = 0;
        stall_pct    <= 0;
        send_saturated(13'd8191, 13'd0);
        send_saturated(13'd0, 13'd8191);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            report_mismatch("words never delivered", pending_words.size(), 0);
        end

        $display("ran %0d pixels over %0d frames with %0d register writes, %0d mid-frame",
                 words_in, frames_seen, reg_writes, reshapes);
        $display("sizes from zero to 8191, four handshake mixes and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
